// File: rtl/pidl_pkg.sv
// pidl_pkg: shared constants, codes and transaction types for the positional list
// no dependencies; imported by every module of the block
package pidl_pkg;

   localparam int DEPTH     = 64;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int VAL_W     = 32;
   localparam int POS_W     = 16;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int CNT_OUT_W = 11;
   // exact sum of DEPTH values never wraps at this width
   localparam int SUM_W     = VAL_W + CNT_W + 1;

   localparam logic signed [VAL_W-1:0] THRESHOLD_RESET = VAL_W'(100);

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [VAL_W-1:0]  old_value;
      logic [POS_W-1:0]         used_position;
      logic [CNT_OUT_W-1:0]     entry_count;
      logic                     sum_over;
   } rsp_type;

   typedef struct packed {
      logic                     en;
      logic                     sub;
      logic signed [VAL_W-1:0]  operand;
   } sum_cmd_type;

endpackage

// File: rtl/pidl_sum.sv
// pidl_sum: running sum of all list entries, one add or subtract per cycle
// depends on pidl_pkg; compares the sum with the threshold register
module pidl_sum (
   input  logic                             clock,
   input  logic                             reset,
   input  pidl_pkg::sum_cmd_type            cmd,
   input  logic signed [pidl_pkg::VAL_W-1:0] threshold,
   output logic                             over
);
   import pidl_pkg::*;

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] operand_ext;
   logic signed [SUM_W-1:0] threshold_ext;

   assign operand_ext   = SUM_W'(cmd.operand);
   assign threshold_ext = SUM_W'(threshold);

   always_comb begin
      sum_in = sum_ff;
      if (cmd.en) begin
         if (cmd.sub) begin
            sum_in = sum_ff - operand_ext;
         end else begin
            sum_in = sum_ff + operand_ext;
         end
      end
   end

   assign over = (sum_ff > threshold_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// File: rtl/pidl_seq.sv
// pidl_seq: sequencer that holds the list memory and moves entries one per cycle
// depends on pidl_pkg; drives the running-sum unit through a command struct
module pidl_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  pidl_pkg::req_type     req_data,
   output logic                  req_stall,
   output pidl_pkg::sum_cmd_type sum_cmd,
   input  logic                  sum_over_now,
   output logic                  res_valid,
   output pidl_pkg::rsp_type     res_data,
   input  logic                  res_taken
);
   import pidl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OLD_RD,
      S_OLD_WAIT,
      S_SHIFT,
      S_WRITE,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [IDX_W-1:0]        used_ff, used_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic signed [VAL_W-1:0] old_ff, old_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    ok_ff, ok_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        wr_ptr_ff, wr_ptr_in;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    mem_rd_en;
   logic [IDX_W-1:0]        mem_rd_addr;
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic signed [VAL_W-1:0] mem_wr_data;

   logic [POS_W-1:0]        count_wide;
   logic [CNT_W-1:0]        ins_pos;
   logic [CNT_W-1:0]        del_pos;
   logic                    is_insert;

   assign count_wide = POS_W'(count_ff);
   // insert past the end appends, delete or change past the end hits the last entry
   assign ins_pos = (req_data.position > count_wide) ? count_ff : CNT_W'(req_data.position);
   assign del_pos = (req_data.position >= count_wide) ? (count_ff - 1'b1)
                                                      : CNT_W'(req_data.position);
   assign is_insert = (func_ff == FUNC_INSERT);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      func_in     = func_ff;
      used_in     = used_ff;
      value_in    = value_ff;
      old_in      = old_ff;
      status_in   = status_ff;
      ok_in       = ok_ff;
      rd_ptr_in   = rd_ptr_ff;
      left_in     = left_ff;
      pend_in     = pend_ff;
      wr_ptr_in   = wr_ptr_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_ptr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = used_ff;
      mem_wr_data = value_ff;
      sum_cmd     = '0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_data.func;
               value_in  = req_data.value;
               old_in    = '0;
               used_in   = '0;
               ok_in     = 1'b0;
               status_in = STATUS_DONE;
               pend_in   = 1'b0;
               state_in  = S_DONE;
               case (req_data.func) inside
                  FUNC_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ok_in     = 1'b1;
                        used_in   = IDX_W'(ins_pos);
                        rd_ptr_in = IDX_W'(count_ff - 1'b1);
                        left_in   = count_ff - ins_pos;
                        state_in  = S_SHIFT;
                     end
                  end
                  FUNC_DELETE, FUNC_CHANGE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        ok_in    = 1'b1;
                        used_in  = IDX_W'(del_pos);
                        state_in = S_OLD_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_OLD_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = used_ff;
            state_in    = S_OLD_WAIT;
         end
         S_OLD_WAIT: begin
            old_in          = rd_data_ff;
            sum_cmd.en      = 1'b1;
            sum_cmd.sub     = 1'b1;
            sum_cmd.operand = rd_data_ff;
            if (func_ff == FUNC_CHANGE) begin
               state_in = S_WRITE;
            end else begin
               rd_ptr_in = used_ff + 1'b1;
               left_in   = count_ff - 1'b1 - CNT_W'(used_ff);
               pend_in   = 1'b0;
               state_in  = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // read one entry ahead, write it one place over on the next cycle
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ptr_ff;
               mem_wr_data = rd_data_ff;
            end
            if (left_ff != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_ptr_ff;
               left_in     = left_ff - 1'b1;
               pend_in     = 1'b1;
               if (is_insert) begin
                  wr_ptr_in = rd_ptr_ff + 1'b1;
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end else begin
                  wr_ptr_in = rd_ptr_ff - 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (is_insert) begin
                     state_in = S_WRITE;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_WRITE: begin
            mem_wr_en       = 1'b1;
            mem_wr_addr     = used_ff;
            mem_wr_data     = value_ff;
            sum_cmd.en      = 1'b1;
            sum_cmd.sub     = 1'b0;
            sum_cmd.operand = value_ff;
            if (is_insert) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      res_data.status        = status_ff;
      res_data.old_value     = old_ff;
      res_data.used_position = POS_W'(used_ff);
      res_data.entry_count   = CNT_OUT_W'(count_ff);
      res_data.sum_over      = ok_ff & sum_over_now;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      func_ff   <= func_in;
      used_ff   <= used_in;
      value_ff  <= value_in;
      old_ff    <= old_in;
      status_ff <= status_in;
      ok_ff     <= ok_in;
      rd_ptr_ff <= rd_ptr_in;
      left_ff   <= left_in;
      wr_ptr_ff <= wr_ptr_in;
   end

endmodule

// File: rtl/positional_insert_delete_list_top.sv
// Positional insertion list: an ordered list of up to 64 signed 32-bit values held
// in a simple dual-port memory, one read port and one write port. Insert, delete and
// change each take one request transaction and give one response transaction. The block
// takes one request at a time: insert and delete move every entry behind the position
// by one place, one entry per cycle through the list memory. A stalled response holds
// the block until the output register takes it. The response sits in an output
// register; the threshold register may be written only while no request is in flight.
// depends on pidl_pkg, pidl_seq and pidl_sum
module positional_insert_delete_list_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pidl_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pidl_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic signed [pidl_pkg::VAL_W-1:0] csr_wr_data
);
   import pidl_pkg::*;

   logic signed [VAL_W-1:0] threshold_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   sum_cmd_type             sum_cmd;
   logic                    sum_over_now;
   logic                    res_valid;
   rsp_type                 res_data;
   logic                    res_taken;

   pidl_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .sum_cmd      (sum_cmd),
      .sum_over_now (sum_over_now),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .res_taken    (res_taken)
   );

   pidl_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .cmd       (sum_cmd),
      .threshold (threshold_ff),
      .over      (sum_over_now)
   );

   // output slot is free when empty or being drained this cycle
   assign res_taken = res_valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for the positional insertion list, driving random and
// directed list operations and comparing every response with a behavioural list model
// depends on pidl_pkg and positional_insert_delete_list_top
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidl_pkg::*;

   // spare operation code, the block treats it as a no-op
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_wr_en;
   logic signed [VAL_W-1:0]  csr_wr_data;

   // model of the list contents, its exact sum and the threshold register
   logic signed [VAL_W-1:0]  list_model[$];
   longint                   list_sum = 0;
   logic signed [VAL_W-1:0]  threshold = THRESHOLD_RESET;
   rsp_type                  pending_results[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_left = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   positional_insert_delete_list_top dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_wr_en,
      .csr_wr_data
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic rsp_type predict_list_op(input req_type r);
      rsp_type                 res;
      int                      n;
      int                      at;
      logic signed [VAL_W-1:0] prev;
      bit                      done;
      res  = '0;
      done = 1'b0;
      n    = list_model.size();
      case (r.func)
         FUNC_INSERT: begin
            if (n >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               // past the end means append
               at = (int'(r.position) > n) ? n : int'(r.position);
               list_model.insert(at, r.value);
               list_sum += longint'($signed(r.value));
               res.used_position = POS_W'(at);
               done = 1'b1;
            end
         end
         FUNC_DELETE, FUNC_CHANGE: begin
            if (n == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               at   = (int'(r.position) >= n) ? n - 1 : int'(r.position);
               prev = list_model[at];
               if (r.func == FUNC_DELETE) begin
                  list_model.delete(at);
                  list_sum -= longint'(prev);
               end else begin
                  list_model[at] = r.value;
                  list_sum += longint'($signed(r.value)) - longint'(prev);
               end
               res.old_value     = prev;
               res.used_position = POS_W'(at);
               done = 1'b1;
            end
         end
         default: ;
      endcase
      res.status      = done ? STATUS_DONE : res.status;
      res.entry_count = CNT_OUT_W'(list_model.size());
      res.sum_over    = done && (list_sum > longint'(threshold));
      return res;
   endfunction

   function automatic req_type make_req(input logic [FUNC_W-1:0] func,
                                        input logic [POS_W-1:0] position,
                                        input logic signed [VAL_W-1:0] value);
      req_type r;
      r.func     = func;
      r.position = position;
      r.value    = value;
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       v = 32'sh7FFFFFFF;
               1:       v = 32'sh80000000;
               2:       v = '0;
               default: v = '1;
            endcase
         end
         // small values keep the sum near the threshold
         1, 2, 3: v = $signed($urandom_range(400)) - 200;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input int n);
      logic [POS_W-1:0] p;
      case ($urandom_range(9))
         0:       p = '0;
         1:       p = '1;
         2, 3:    p = POS_W'($urandom);
         default: p = POS_W'($urandom_range(n));
      endcase
      return p;
   endfunction

   function automatic req_type random_op(input int insert_pct);
      req_type r;
      int      roll;
      roll = $urandom_range(99);
      if (roll < 3) begin
         r.func = FUNC_NONE;
      end else if (roll < 3 + insert_pct) begin
         r.func = FUNC_INSERT;
      end else if (roll[0]) begin
         r.func = FUNC_DELETE;
      end else begin
         r.func = FUNC_CHANGE;
      end
      r.position = pick_position(list_model.size());
      r.value    = pick_value();
      return r;
   endfunction

   // offer one transaction and predict its response once it is taken
   task automatic send_req(input req_type r);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_list_op(r));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [VAL_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      threshold = v;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic compare_field(input string field, input logic [63:0] wanted,
                                input logic [63:0] got);
      if (wanted !== got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, wanted, got);
         error_count++;
      end
   endtask

   task automatic test_directed();
      send_req(make_req(FUNC_DELETE, 16'd0,    32'sd0));
      send_req(make_req(FUNC_CHANGE, 16'hFFFF, 32'sd5));
      send_req(make_req(FUNC_NONE,   16'hFFFF, -32'sd1));
      send_req(make_req(FUNC_INSERT, 16'hFFFF, 32'sh7FFFFFFF));
      send_req(make_req(FUNC_INSERT, 16'd0,    32'sh80000000));
      send_req(make_req(FUNC_INSERT, 16'd1,    32'sd0));
      send_req(make_req(FUNC_INSERT, 16'd3,    -32'sd1));
      send_req(make_req(FUNC_INSERT, 16'h8000, 32'sd101));
      send_req(make_req(FUNC_CHANGE, 16'hFFFF, 32'sd100));
      send_req(make_req(FUNC_CHANGE, 16'd0,    32'sh55555555));
      send_req(make_req(FUNC_CHANGE, 16'd2,    -32'sd1));
      send_req(make_req(FUNC_NONE,   16'd2,    32'sh7FFFFFFF));
      send_req(make_req(FUNC_DELETE, 16'hFFFF, 32'sd7));
      send_req(make_req(FUNC_DELETE, 16'd4,    32'sd0));
      send_req(make_req(FUNC_DELETE, 16'd1,    32'sd0));
      send_req(make_req(FUNC_DELETE, 16'd0,    32'sd0));
      send_req(make_req(FUNC_DELETE, 16'd0,    32'sd0));
      send_req(make_req(FUNC_DELETE, 16'd1,    32'sd0));
      // sum equal to the threshold must not raise the flag
      send_req(make_req(FUNC_INSERT, 16'd0,    32'sd100));
      send_req(make_req(FUNC_INSERT, 16'd0,    32'sd1));
      send_req(make_req(FUNC_INSERT, 16'h5555, 32'shAAAAAAAA));
      send_req(make_req(FUNC_INSERT, 16'hAAAA, 32'sh55555555));
   endtask

   task automatic test_full_list();
      drain_results();
      write_threshold(32'sh7FFFFFFF);
      while (list_model.size() < DEPTH) begin
         send_req(make_req(FUNC_INSERT, pick_position(list_model.size()),
                           $signed($urandom_range(32'h7FFFFFFF, 32'h30000000))));
      end
      repeat (4) send_req(make_req(FUNC_INSERT, POS_W'($urandom), pick_value()));
      repeat (4) send_req(make_req(FUNC_CHANGE, pick_position(DEPTH), pick_value()));
      drain_results();
      write_threshold(32'sh80000000);
      while (list_model.size() > 0) begin
         send_req(make_req(FUNC_DELETE, pick_position(list_model.size()), pick_value()));
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic signed [VAL_W-1:0] thr, input int n);
      drain_results();
      write_threshold(thr);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      // alternate phases that favour inserts with phases that favour deletes and changes
      for (int i = 0; i < n; i++) send_req(random_op(((i / 80) % 2 == 0) ? 70 : 30));
   endtask

   task automatic test_backpressure();
      drain_results();
      write_threshold(pick_value());
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (30) send_req(random_op(50));
   endtask

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: expected none, got %h", $time, rsp_data);
            error_count++;
         end else begin
            wanted = pending_results.pop_front();
            compare_field("status",        wanted.status,        rsp_data.status);
            compare_field("old_value",     wanted.old_value,     rsp_data.old_value);
            compare_field("used_position", wanted.used_position, rsp_data.used_position);
            compare_field("entry_count",   wanted.entry_count,   rsp_data.entry_count);
            compare_field("sum_over",      wanted.sum_over,      rsp_data.sum_over);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_list();
      test_random_traffic(0,  0,  32'sd0,    360);
      test_random_traffic(53, 0,  -32'sd150, 360);
      test_random_traffic(0,  53, $urandom,  360);
      test_random_traffic(18, 18, 32'sd150,  360);
      test_backpressure();
      drain_results();
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
